// ===== hw/rtl/mec_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time pixel colorer.
// Used by the controller, the datapath, the divider and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mec_pkg;

    // Fixed field widths
    localparam int INT_BITS   = 4;    // integer bits of the fixed-point word
    localparam int CFG_BITS   = 32;   // register data width
    localparam int STEP_BITS  = 31;   // pixel step register width
    localparam int ITER_BITS  = 16;   // iteration count width
    localparam int COLOR_BITS = 24;   // packed RGB width
    localparam int CHAN_BITS  = 8;    // one color channel
    localparam int CALC_BITS  = 64;   // width of the coordinate sums
    localparam int ADDR_BITS  = 4;    // APB byte address width

    // Constants of the coloring and the escape test
    localparam int unsigned           ESCAPE_RADIUS_SQ = 4;
    localparam logic [CHAN_BITS-1:0]  CHANNEL_MAX      = 8'hFF;

    // Register reset values
    localparam logic [CFG_BITS-1:0]   X_MIN_RESET      = 32'hE000_0000;
    localparam logic [CFG_BITS-1:0]   Y_MAX_RESET      = 32'h1000_0000;
    localparam logic [STEP_BITS-1:0]  STEP_RESET       = 31'd805306;
    localparam logic [ITER_BITS-1:0]  ITER_RESET       = 16'd5000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take row/col, form the coordinate products
        logic coord;     // form c, load z = c, count = 1
        logic mul;       // register the partial products of the three lanes
        logic add;       // combine partial products into full products
        logic step;      // z = z^2 + c, count + 1
        logic finish;    // latch inside flag, start the color divide on escape
        logic load_out;  // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic escape;    // |z|^2 > 4 for the current z
        logic at_limit;  // count has reached the iteration limit
        logic div_done;  // color divide finishes this cycle
    } t_dp_sts;

endpackage

// ===== hw/rtl/mec_div.sv =====
// Restoring divider for the pixel color: floor(count * 16777215 / limit).
// One quotient bit per cycle.
// Depends on mec_pkg.
`timescale 1ns / 1ps

module mec_div import mec_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ITER_BITS-1:0]  i_count,
    input  logic [ITER_BITS-1:0]  i_limit,
    output logic                  o_done,
    output logic [COLOR_BITS-1:0] o_quot
);

    localparam int NUM_BITS = ITER_BITS + COLOR_BITS;
    localparam int CNT_BITS = $clog2(COLOR_BITS);

    logic [NUM_BITS-1:0]   numer;
    logic [ITER_BITS:0]    trial;
    logic [ITER_BITS:0]    diff;
    logic                  fits;

    logic [ITER_BITS-1:0]  r_rem;
    logic [COLOR_BITS-1:0] r_quo;
    logic [ITER_BITS-1:0]  r_den;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_busy;

    // count * (2^24 - 1); the upper part is count - 1, already below the limit
    assign numer = {i_count, COLOR_BITS'(0)} - NUM_BITS'(i_count);

    assign trial = {r_rem, r_quo[COLOR_BITS-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(COLOR_BITS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= numer[NUM_BITS-1:COLOR_BITS];
            r_quo <= numer[COLOR_BITS-1:0];
            r_den <= i_limit;
        end else if (r_busy) begin
            r_rem <= fits ? diff[ITER_BITS-1:0] : trial[ITER_BITS-1:0];
            r_quo <= {r_quo[COLOR_BITS-2:0], fits};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_quo;

endmodule

// ===== hw/rtl/mec_dp.sv =====
// Datapath: pixel coordinates, three split multiplier lanes for zr^2, zi^2 and zr*zi,
// escape test, z update, iteration count, color divider and result register.
// Depends on mec_pkg and mec_div.
`timescale 1ns / 1ps

module mec_dp import mec_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [CFG_BITS-1:0]   i_x_min,
    input  logic [CFG_BITS-1:0]   i_y_max,
    input  logic [STEP_BITS-1:0]  i_pixel_step,
    input  logic [ITER_BITS-1:0]  i_max_iter,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [COORD_BITS-1:0] i_col,
    output logic [CHAN_BITS-1:0]  o_red,
    output logic [CHAN_BITS-1:0]  o_green,
    output logic [CHAN_BITS-1:0]  o_blue,
    output logic                  o_inside_res,
    output logic [ITER_BITS-1:0]  o_escape_count
);

    localparam int W     = FRAC_BITS + INT_BITS;   // word width
    localparam int LW    = W / 2;                  // unsigned low half
    localparam int HW    = W - LW;                 // signed high half
    localparam int PW    = 2 * W;                  // full product
    localparam int MW    = HW + LW + 1;            // cross partial product
    localparam int SW    = MW + 1;                 // sum of the two cross partials
    localparam int QW    = PW - FRAC_BITS;         // truncated square
    localparam int PRODC = COORD_BITS + STEP_BITS;
    localparam int LANES = 3;

    localparam logic [QW:0] ESC_LIM = (QW + 1)'(ESCAPE_RADIUS_SQ) << FRAC_BITS;

    logic [PRODC-1:0]      r_col_prod;
    logic [PRODC-1:0]      r_row_prod;
    logic [W-1:0]          r_x;
    logic [W-1:0]          r_y;
    logic [W-1:0]          r_zr;
    logic [W-1:0]          r_zi;
    logic [ITER_BITS-1:0]  r_j;
    logic                  r_inside;

    logic signed [2*HW-1:0] r_hh [LANES];
    logic signed [MW-1:0]   r_hl [LANES];
    logic signed [MW-1:0]   r_lh [LANES];
    logic [2*LW-1:0]        r_ll [LANES];
    logic [PW-1:0]          r_p  [LANES];

    logic signed [2*HW-1:0] n_hh [LANES];
    logic signed [MW-1:0]   n_hl [LANES];
    logic signed [MW-1:0]   n_lh [LANES];
    logic [2*LW-1:0]        n_ll [LANES];
    logic [PW-1:0]          n_p  [LANES];
    logic [SW-1:0]          mid  [LANES];
    logic [W-1:0]           op_a [LANES];
    logic [W-1:0]           op_b [LANES];

    logic [CALC_BITS-1:0]  x_sum;
    logic [CALC_BITS-1:0]  y_sum;
    logic [QW-1:0]         sq_r;
    logic [QW-1:0]         sq_i;
    logic [QW:0]           sq_sum;
    logic [W-1:0]          n_zr;
    logic [W-1:0]          n_zi;
    logic [ITER_BITS-1:0]  m_eff;
    logic                  escape;
    logic                  div_done;
    logic [COLOR_BITS-1:0] quot;

    logic [CHAN_BITS-1:0]  r_red;
    logic [CHAN_BITS-1:0]  r_green;
    logic [CHAN_BITS-1:0]  r_blue;
    logic                  r_out_inside;
    logic [ITER_BITS-1:0]  r_out_count;

    // c = (x_min + col*step, y_max - row*step), wrapped to the word
    assign x_sum = {{(CALC_BITS-CFG_BITS){i_x_min[CFG_BITS-1]}}, i_x_min}
                 + CALC_BITS'(r_col_prod);
    assign y_sum = {{(CALC_BITS-CFG_BITS){i_y_max[CFG_BITS-1]}}, i_y_max}
                 - CALC_BITS'(r_row_prod);

    // lane 0: zr*zr, lane 1: zi*zi, lane 2: zr*zi
    always_comb begin
        op_a[0] = r_zr;  op_b[0] = r_zr;
        op_a[1] = r_zi;  op_b[1] = r_zi;
        op_a[2] = r_zr;  op_b[2] = r_zi;
    end

    // split each operand into a signed high half and an unsigned low half
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_hh[k] = $signed(op_a[k][W-1:LW]) * $signed(op_b[k][W-1:LW]);
            n_hl[k] = $signed(op_a[k][W-1:LW]) * $signed({1'b0, op_b[k][LW-1:0]});
            n_lh[k] = $signed({1'b0, op_a[k][LW-1:0]}) * $signed(op_b[k][W-1:LW]);
            n_ll[k] = op_a[k][LW-1:0] * op_b[k][LW-1:0];
        end
    end

    // high and low partials sit side by side; add the cross terms at the middle
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            mid[k] = {r_hl[k][MW-1], r_hl[k]} + {r_lh[k][MW-1], r_lh[k]};
            n_p[k] = {r_hh[k], r_ll[k]}
                   + ({{(PW-SW){mid[k][SW-1]}}, mid[k]} << LW);
        end
    end

    // squares are non-negative, so their truncated sum never wraps
    assign sq_r   = r_p[0][PW-1:FRAC_BITS];
    assign sq_i   = r_p[1][PW-1:FRAC_BITS];
    assign sq_sum = {1'b0, sq_r} + {1'b0, sq_i};
    assign escape = (sq_sum > ESC_LIM);

    // 2*zr*zi is the product shifted by one bit less
    assign n_zr = r_p[0][FRAC_BITS+W-1:FRAC_BITS] - r_p[1][FRAC_BITS+W-1:FRAC_BITS] + r_x;
    assign n_zi = r_p[2][FRAC_BITS+W-2:FRAC_BITS-1] + r_y;

    // a limit of zero acts as one
    assign m_eff = (i_max_iter == '0) ? ITER_BITS'(1) : i_max_iter;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col_prod <= i_col * i_pixel_step;
            r_row_prod <= i_row * i_pixel_step;
        end
        if (i_cmd.coord) begin
            r_x  <= x_sum[W-1:0];
            r_y  <= y_sum[W-1:0];
            r_zr <= x_sum[W-1:0];
            r_zi <= y_sum[W-1:0];
            r_j  <= ITER_BITS'(1);
        end
        if (i_cmd.mul) begin
            for (int k = 0; k < LANES; k++) begin
                r_hh[k] <= n_hh[k];
                r_hl[k] <= n_hl[k];
                r_lh[k] <= n_lh[k];
                r_ll[k] <= n_ll[k];
            end
        end
        if (i_cmd.add) begin
            for (int k = 0; k < LANES; k++) begin
                r_p[k] <= n_p[k];
            end
        end
        if (i_cmd.step) begin
            r_zr <= n_zr;
            r_zi <= n_zi;
            r_j  <= r_j + 1'b1;
        end
        if (i_cmd.finish) begin
            r_inside <= !escape;
        end
        if (i_cmd.load_out) begin
            r_red        <= r_inside ? CHANNEL_MAX : quot[2*CHAN_BITS +: CHAN_BITS];
            r_green      <= r_inside ? CHANNEL_MAX : quot[CHAN_BITS +: CHAN_BITS];
            r_blue       <= r_inside ? CHANNEL_MAX : quot[0 +: CHAN_BITS];
            r_out_inside <= r_inside;
            r_out_count  <= r_inside ? '0 : r_j;
        end
    end

    mec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.finish && escape),
        .i_count (r_j),
        .i_limit (m_eff),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        o_sts.escape   = escape;
        o_sts.at_limit = (r_j >= m_eff);
        o_sts.div_done = div_done;
    end

    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_inside_res   = r_out_inside;
    assign o_escape_count = r_out_count;

endmodule

// ===== hw/rtl/mec_ctrl.sv =====
// Controller: sequences capture, the multiply/combine/test iteration loop,
// the color divide and the result handoff. Depends on mec_pkg.
`timescale 1ns / 1ps

module mec_ctrl import mec_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COORD,
        S_MUL,
        S_ADD,
        S_TEST,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_COORD;
                end
            end
            S_COORD: begin
                o_cmd.coord = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_TEST;
            end
            S_TEST: begin
                if (i_sts.escape || i_sts.at_limit) begin
                    o_cmd.finish = 1'b1;
                    n_state      = i_sts.escape ? S_DIV : S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register is free or drains this cycle
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== hw/rtl/mandelbrot_escape_pixel_color.sv =====
// Top level of the Mandelbrot escape-time pixel colorer: APB register file,
// controller and datapath. Depends on mec_pkg, mec_ctrl and mec_dp.
//
// Usage
//   Input channel (i_valid/o_ready): one transfer carries a pixel row and column.
//   Output channel (o_valid/i_ready): one transfer per pixel carries red, green,
//   blue, the inside flag and the escape count, in input order.
//   APB port: x_min at 0x0, y_max at 0x4, pixel_step at 0x8, max_iterations at
//   0xC. Write only while no pixel is in flight; reads return the stored value.
// Sequence
//   Pixels are worked one at a time. Each escape-time iteration runs the states
//   partial products, product combine, and escape test with z update; a pixel
//   that escapes then goes through the bit-serial color divide. When the loop or
//   the divide ends, the controller waits in its done state until the output
//   register is free or drains, and then loads the result into it.
// Reset and stall
//   Reset (synchronous, active low) returns the registers to their defaults,
//   drops any pixel in flight and empties the output register.
//   While the receiver stalls, the held result stays put and the next pixel is
//   still taken and worked; it waits after its loop until the result register frees.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_color import mec_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [COORD_BITS-1:0] i_col,
    // color output
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CHAN_BITS-1:0]  o_red,
    output logic [CHAN_BITS-1:0]  o_green,
    output logic [CHAN_BITS-1:0]  o_blue,
    output logic                  o_inside_res,
    output logic [ITER_BITS-1:0]  o_escape_count,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [CFG_BITS-1:0]   pwdata,
    output logic [CFG_BITS-1:0]   prdata,
    output logic                  pready
);

    // register index codes (word address)
    localparam logic [1:0] REG_X_MIN      = 2'd0;
    localparam logic [1:0] REG_Y_MAX      = 2'd1;
    localparam logic [1:0] REG_PIXEL_STEP = 2'd2;
    localparam logic [1:0] REG_MAX_ITER   = 2'd3;

    logic [CFG_BITS-1:0]  r_x_min;
    logic [CFG_BITS-1:0]  r_y_max;
    logic [STEP_BITS-1:0] r_pixel_step;
    logic [ITER_BITS-1:0] r_max_iter;

    logic [1:0] reg_sel;
    logic       cfg_wr;
    t_dp_cmd    dp_cmd;
    t_dp_sts    dp_sts;

    // byte address to register index; no wait states
    assign reg_sel = paddr[ADDR_BITS-1:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min      <= X_MIN_RESET;
            r_y_max      <= Y_MAX_RESET;
            r_pixel_step <= STEP_RESET;
            r_max_iter   <= ITER_RESET;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_X_MIN:      r_x_min      <= pwdata;
                REG_Y_MAX:      r_y_max      <= pwdata;
                REG_PIXEL_STEP: r_pixel_step <= pwdata[STEP_BITS-1:0];
                REG_MAX_ITER:   r_max_iter   <= pwdata[ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back, zero-extended to the bus
    always_comb begin
        case (reg_sel)
            REG_X_MIN:      prdata = r_x_min;
            REG_Y_MAX:      prdata = r_y_max;
            REG_PIXEL_STEP: prdata = CFG_BITS'(r_pixel_step);
            REG_MAX_ITER:   prdata = CFG_BITS'(r_max_iter);
            default:        prdata = '0;
        endcase
    end

    // sequence each pixel through capture, iteration loop, divide and handoff
    mec_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    // coordinates, z^2 + c lanes, escape test, color divide, result register
    mec_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_x_min        (r_x_min),
        .i_y_max        (r_y_max),
        .i_pixel_step   (r_pixel_step),
        .i_max_iter     (r_max_iter),
        .i_row          (i_row),
        .i_col          (i_col),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_inside_res   (o_inside_res),
        .o_escape_count (o_escape_count)
    );

endmodule

// ===== tb/mec_tb_pkg.sv =====
// Testbench constants for the Mandelbrot pixel colorer: block sizes and register map.
// Depends on mec_pkg for the address, integer and color widths.
`timescale 1ns / 1ps

package mec_tb_pkg;
    import mec_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int WORD_BITS  = FRAC_BITS + INT_BITS;

    localparam logic [COLOR_BITS-1:0] COLOR_FULL = 24'hFF_FFFF;

    // APB byte addresses of the configuration registers
    typedef enum logic [ADDR_BITS-1:0] {
        REG_X_MIN      = 4'h0,
        REG_Y_MAX      = 4'h4,
        REG_STEP       = 4'h8,
        REG_ITER_LIMIT = 4'hC
    } t_mec_reg;

endpackage

// ===== tb/mec_color_checker.sv =====
// Checker for the Mandelbrot pixel colorer: snoops APB writes, predicts each pixel's color
// from the accepted row and column and compares the output transfers in order.
// Depends on mec_pkg and mec_tb_pkg.
`timescale 1ns / 1ps

module mec_color_checker import mec_pkg::*, mec_tb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [CHAN_BITS-1:0]  i_red,
    input  logic [CHAN_BITS-1:0]  i_green,
    input  logic [CHAN_BITS-1:0]  i_blue,
    input  logic                  i_inside_res,
    input  logic [ITER_BITS-1:0]  i_escape_count,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [ADDR_BITS-1:0]  i_paddr,
    input  logic [CFG_BITS-1:0]   i_pwdata,
    output int unsigned           o_fail_count = 0,
    output int unsigned           o_pending = 0
);

    localparam logic signed [63:0] ESC_BOUND = 64'(ESCAPE_RADIUS_SQ) << FRAC_BITS;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic                 in_set;
        logic [ITER_BITS-1:0] count;
    } t_pixel_color;

    logic [CFG_BITS-1:0]  x_min_q;
    logic [CFG_BITS-1:0]  y_max_q;
    logic [STEP_BITS-1:0] step_q;
    logic [ITER_BITS-1:0] iter_limit_q;

    t_pixel_color color_q[$];
    int unsigned  fail_count = 0;

    function automatic t_pixel_color predict_color(input logic [COORD_BITS-1:0] row,
                                                   input logic [COORD_BITS-1:0] col);
        logic [63:0]        x_wide, y_wide, shade;
        logic signed [63:0] c_re, c_im, z_re, z_im, sq_re, sq_im, acc;
        int unsigned        limit, count;
        bit                 escaped;
        t_pixel_color       res;
        // a zero limit runs like a limit of one
        limit  = (iter_limit_q == '0) ? 1 : iter_limit_q;
        // point coordinates in 64 bits, then wrapped to the word
        x_wide = {{32{x_min_q[31]}}, x_min_q} + 64'(col) * 64'(step_q);
        y_wide = {{32{y_max_q[31]}}, y_max_q} - 64'(row) * 64'(step_q);
        c_re   = 64'(signed'(x_wide[WORD_BITS-1:0]));
        c_im   = 64'(signed'(y_wide[WORD_BITS-1:0]));
        z_re   = c_re;
        z_im   = c_im;
        count  = 1;
        forever begin
            sq_re   = (z_re * z_re) >>> FRAC_BITS;
            sq_im   = (z_im * z_im) >>> FRAC_BITS;
            escaped = sq_re > ESC_BOUND || sq_im > ESC_BOUND || sq_re + sq_im > ESC_BOUND;
            if (escaped || count >= limit) break;
            // 2*zr*zi from one shift less; both sums wrap to the word
            acc   = ((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im;
            z_im  = 64'(signed'(acc[WORD_BITS-1:0]));
            acc   = sq_re - sq_im + c_re;
            z_re  = 64'(signed'(acc[WORD_BITS-1:0]));
            count++;
        end
        if (!escaped) begin
            res.red    = CHANNEL_MAX;
            res.green  = CHANNEL_MAX;
            res.blue   = CHANNEL_MAX;
            res.in_set = 1'b1;
            res.count  = '0;
        end else begin
            shade      = (64'(count) * 64'(COLOR_FULL)) / 64'(limit);
            res.red    = shade[23:16];
            res.green  = shade[15:8];
            res.blue   = shade[7:0];
            res.in_set = 1'b0;
            res.count  = count[ITER_BITS-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_color got, want;
        if (!i_rst_n) begin
            x_min_q      = X_MIN_RESET;
            y_max_q      = Y_MAX_RESET;
            step_q       = STEP_RESET;
            iter_limit_q = ITER_RESET;
            color_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    REG_X_MIN:      x_min_q      = i_pwdata;
                    REG_Y_MAX:      y_max_q      = i_pwdata;
                    REG_STEP:       step_q       = i_pwdata[STEP_BITS-1:0];
                    REG_ITER_LIMIT: iter_limit_q = i_pwdata[ITER_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_red, i_green, i_blue, i_inside_res, i_escape_count};
                if (color_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: color transfer with no pixel pending: ",
                                 $realtime,
                                 "r=%0d g=%0d b=%0d in=%0d n=%0d",
                                 got.red, got.green, got.blue, got.in_set, got.count);
                end else begin
                    want = color_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.in_set !== want.in_set ||
                        got.count !== want.count) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: color mismatch: ", $realtime,
                                     "expected r=%0d g=%0d b=%0d in=%0d n=%0d, ",
                                     want.red, want.green, want.blue, want.in_set,
                                     want.count,
                                     "got r=%0d g=%0d b=%0d in=%0d n=%0d",
                                     got.red, got.green, got.blue, got.in_set,
                                     got.count);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                color_q.push_back(predict_color(i_row, i_col));
        end
        o_pending    <= color_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/tb_mandelbrot_escape_pixel_color.sv =====
// Top of the Mandelbrot pixel colorer testbench: clock, reset, APB programming, pixel
// stimulus and the verdict. Depends on mec_pkg, mec_tb_pkg, mec_color_checker and the block.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_pixel_color import mec_pkg::*, mec_tb_pkg::*;;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [COORD_BITS-1:0] i_row   = '0;
    logic [COORD_BITS-1:0] i_col   = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [CHAN_BITS-1:0]  o_red, o_green, o_blue;
    logic                  o_inside_res;
    logic [ITER_BITS-1:0]  o_escape_count;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_BITS-1:0]  paddr   = '0;
    logic [CFG_BITS-1:0]   pwdata  = '0;
    logic [CFG_BITS-1:0]   prdata;
    logic                  pready;

    int unsigned fail_count;
    int unsigned pixels_pending;

    // Idle percentages of the current phase: sender gaps and receiver stalls per cycle
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    mandelbrot_escape_pixel_color #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_row          (i_row),
        .i_col          (i_col),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_inside_res   (o_inside_res),
        .o_escape_count (o_escape_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    mec_color_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_red          (o_red),
        .i_green        (o_green),
        .i_blue         (o_blue),
        .i_inside_res   (o_inside_res),
        .i_escape_count (o_escape_count),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pixels_pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: stall at the phase's rate, never when the rate is zero
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop well beyond the slowest legal run (one 65535-iteration inside pixel
    // dominates, the rest are short loops)
    initial begin
        #30000000;
        $display("Verification failed");
        $finish;
    end

    // Write one register: setup cycle, then access cycle; the write lands at the access edge
    task automatic apb_write(input t_mec_reg addr, input logic [CFG_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Program the full view: left edge, top edge, pixel step and iteration limit
    task automatic load_view(input logic [CFG_BITS-1:0] x0, input logic [CFG_BITS-1:0] y0,
                             input logic [STEP_BITS-1:0] step,
                             input logic [ITER_BITS-1:0] limit);
        apb_write(REG_X_MIN, x0);
        apb_write(REG_Y_MAX, y0);
        apb_write(REG_STEP, {1'b0, step});
        apb_write(REG_ITER_LIMIT, {16'd0, limit});
    endtask

    // Offer one pixel; return right after the edge at which it transfers.
    // Valid stays high into the next pixel unless a gap is drawn.
    task automatic send_pixel(input logic [COORD_BITS-1:0] row,
                              input logic [COORD_BITS-1:0] col);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_row   <= row;
        i_col   <= col;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every accepted pixel has delivered its color
    task automatic settle();
        i_valid <= 1'b0;
        // wait an edge so the checker's count includes the last transfer
        @(posedge i_clk);
        while (pixels_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_BITS-1:0]  x0, y0;
        logic [STEP_BITS-1:0] step;
        logic [ITER_BITS-1:0] limit;

        // Hold reset, then release it once for the whole run
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset view: corners escape at once, one pixel deep in the cardioid,
        // one on the real axis at the left tip
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd333, 12'd500);
        send_pixel(12'd333, 12'd0);
        settle();

        // Zero limit behaves like one: escaped points get full color, inside stays white
        load_view(X_MIN_RESET, Y_MAX_RESET, STEP_RESET, 16'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd333, 12'd500);
        settle();
        apb_write(REG_ITER_LIMIT, 32'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd333, 12'd500);
        settle();

        // Coordinate overflow: largest edges and step wrap the point coordinates
        load_view(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 16'd3);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd4095, 12'd0);
        settle();

        // Largest limit with the smallest step: the origin stays bounded all the way
        load_view(32'd0, 32'd0, 31'd1, 16'hFFFF);
        send_pixel(12'd0, 12'd0);
        settle();

        // Opposite extreme edges: immediate escape under the largest limit
        load_view(32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 16'hFFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        settle();

        // Random phases: none idle, sender idle, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    limit          = ITER_BITS'($urandom_range(32, 256));
                end
                1: begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 0;
                    limit          = ITER_BITS'($urandom_range(2, 64));
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 60;
                    limit          = ITER_BITS'($urandom_range(0, 16));
                end
                default: begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                    limit          = ITER_BITS'($urandom_range(100, 300));
                end
            endcase
            if (phase == 2) begin
                // arbitrary words: mostly wrapped, far-out points
                x0   = $urandom();
                y0   = $urandom();
                step = STEP_BITS'($urandom_range(1, 32'h7FFF_FFFF));
            end else begin
                // a window that frames the set, so many pixels iterate deep
                x0   = 32'd0 - $urandom_range(402653184, 671088640);
                y0   = $urandom_range(268435456, 402653184);
                step = STEP_BITS'($urandom_range(100000, 400000));
            end
            load_view(x0, y0, step, limit);
            repeat (30) send_pixel(COORD_BITS'($urandom_range(4095)),
                                   COORD_BITS'($urandom_range(4095)));
            settle();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
